// File: rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ARWC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define ARWC_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("assertion failed");
`else
`define ARWC_ASSERT(lbl, prop)
`define ARWC_ASSERT_RST(lbl, prop)
`endif
`endif

// File: rtl/arwc_pkg.sv
package arwc_pkg;

    localparam int WORD_W    = 64;
    localparam int BIT_IDX_W = 6;
    localparam int CNT_W     = 64;

    typedef struct packed {
        logic load;
        logic cmp;
        logic clear;
        logic shift_rd;
        logic test_wr;
    } t_cmd;

    typedef struct packed {
        logic old;
        logic greater;
        logic big;
        logic idx_zero;
        logic hit;
    } t_sts;

endpackage

// File: rtl/anti_replay_window_check_core.sv
// anti-replay window check, one 64-bit counter in, one accept bit out
// a too-old counter goes from compare straight to done; any other takes a test read and
//   a test write, preceded by the shift loop and a drain step when the window moves forward
//   by less than its width; the shift loop moves one word per cycle; new counters only in idle
// reset: synchronous active low, clears the highest counter and all bitmap valid bits at once
module anti_replay_window_check_core #(
    parameter int WINDOW_BITS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] counter
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [0] accepted, [7:1] zero
);

    arwc_pkg::t_cmd cmd;
    arwc_pkg::t_sts sts;
    logic           accepted;

    arwc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .o_s_tready   (o_s_axis_tready),
        .o_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .o_m_accepted (accepted),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    arwc_datapath #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_counter (i_s_axis_tdata),
        .i_cmd     (cmd),
        .o_sts     (sts)
    );

    assign o_m_axis_tdata = {7'd0, accepted};

endmodule

// File: rtl/arwc_datapath.sv
module arwc_datapath #(
    parameter int WINDOW_BITS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [arwc_pkg::CNT_W-1:0]  i_counter,
    input  arwc_pkg::t_cmd              i_cmd,
    output arwc_pkg::t_sts              o_sts
);

    localparam int WORDS = WINDOW_BITS / arwc_pkg::WORD_W;
    localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int OFF_W = $clog2(WINDOW_BITS);

    logic [arwc_pkg::CNT_W-1:0]     r_counter;
    logic [arwc_pkg::CNT_W-1:0]     r_highest;
    logic [OFF_W-1:0]               r_off;
    logic [OFF_W-1:0]               r_shift;
    logic [IDX_W-1:0]               r_idx;

    logic [arwc_pkg::WORD_W-1:0]    r_mem [WORDS];
    logic [WORDS-1:0]               r_valid;
    logic [arwc_pkg::WORD_W-1:0]    r_qa;
    logic [arwc_pkg::WORD_W-1:0]    r_qb;
    logic                           r_va;
    logic                           r_vb;

    logic                           r_p_valid;
    logic [IDX_W-1:0]               r_p_idx;
    logic                           r_p_aok;
    logic                           r_p_bok;

    logic [arwc_pkg::CNT_W-1:0]     dgt;
    logic [arwc_pkg::CNT_W-1:0]     dlt;
    logic                           greater;
    logic                           less;
    logic [IDX_W-1:0]               ws;
    logic [arwc_pkg::BIT_IDX_W-1:0] bs;
    logic                           a_ok;
    logic                           b_ok;
    logic [IDX_W-1:0]               sra;
    logic [IDX_W-1:0]               srb;
    logic [IDX_W-1:0]               tw;
    logic [IDX_W-1:0]               ra;
    logic [arwc_pkg::WORD_W-1:0]    qa_m;
    logic [arwc_pkg::WORD_W-1:0]    qb_m;
    logic                           hit;
    logic [arwc_pkg::WORD_W-1:0]    wd_shift;
    logic [arwc_pkg::WORD_W-1:0]    wd_test;
    logic                           we;
    logic [IDX_W-1:0]               wa;
    logic [arwc_pkg::WORD_W-1:0]    wd;

    always_comb begin
        dgt     = r_counter - r_highest;
        dlt     = r_highest - r_counter;
        greater = r_counter > r_highest;
        less    = r_counter < r_highest;
        ws      = IDX_W'(r_shift >> arwc_pkg::BIT_IDX_W);
        bs      = r_shift[arwc_pkg::BIT_IDX_W-1:0];
        a_ok    = r_idx >= ws;
        b_ok    = r_idx > ws;
        sra     = r_idx - ws;
        srb     = sra - IDX_W'(1);
        tw      = IDX_W'(r_off >> arwc_pkg::BIT_IDX_W);
        ra      = i_cmd.shift_rd ? sra : tw;
        qa_m    = r_va ? r_qa : '0;
        qb_m    = r_vb ? r_qb : '0;
        hit     = qa_m[r_off[arwc_pkg::BIT_IDX_W-1:0]];

        wd_shift = '0;
        if (r_p_aok) begin
            wd_shift = qa_m << bs;
        end
        if (r_p_bok && (bs != '0)) begin
            wd_shift = wd_shift | (qb_m >> (7'd64 - {1'b0, bs}));
        end
        wd_test = qa_m | (arwc_pkg::WORD_W'(1) << r_off[arwc_pkg::BIT_IDX_W-1:0]);

        we = r_p_valid || (i_cmd.test_wr && !hit);
        wa = r_p_valid ? r_p_idx : tw;
        wd = r_p_valid ? wd_shift : wd_test;
    end

    assign o_sts.old      = less && (dlt >= arwc_pkg::CNT_W'(WINDOW_BITS));
    assign o_sts.greater  = greater;
    assign o_sts.big      = greater && (dgt >= arwc_pkg::CNT_W'(WINDOW_BITS));
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.hit      = hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_counter <= i_counter;
        end
        if (i_cmd.cmp) begin
            r_off   <= greater ? '0 : dlt[OFF_W-1:0];
            r_shift <= dgt[OFF_W-1:0];
            r_idx   <= IDX_W'(WORDS - 1);
        end else if (i_cmd.shift_rd) begin
            r_idx <= r_idx - IDX_W'(1);
        end
        r_p_idx <= r_idx;
        r_p_aok <= a_ok;
        r_p_bok <= b_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest <= '0;
            r_p_valid <= 1'b0;
        end else begin
            if (i_cmd.cmp && greater) begin
                r_highest <= r_counter;
            end
            r_p_valid <= i_cmd.shift_rd;
        end
    end

    // word store, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_qa <= r_mem[ra];
        r_qb <= r_mem[srb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (we) begin
                r_valid[wa] <= 1'b1;
            end
            r_va <= r_valid[ra];
            r_vb <= r_valid[srb];
        end
    end

endmodule

// File: rtl/arwc_ctrl.sv
`include "assert_macros.svh"

module arwc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic           o_m_accepted,
    output arwc_pkg::t_cmd o_cmd,
    input  arwc_pkg::t_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SHIFT,
        S_DRAIN,
        S_TRD,
        S_TWR,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_res;
    logic   r_out_valid;
    logic   r_out_acc;

    assign o_s_tready   = (r_state == S_IDLE);
    assign o_m_tvalid   = r_out_valid;
    assign o_m_accepted = r_out_acc;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_s_tvalid;
            end
            S_CMP: begin
                o_cmd.cmp   = 1'b1;
                o_cmd.clear = i_sts.big;
            end
            S_SHIFT: begin
                o_cmd.shift_rd = 1'b1;
            end
            S_TWR: begin
                o_cmd.test_wr = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_acc   <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (i_sts.old) begin
                        r_res   <= 1'b0;
                        r_state <= S_DONE;
                    end else if (i_sts.greater && !i_sts.big) begin
                        r_state <= S_SHIFT;
                    end else begin
                        r_state <= S_TRD;
                    end
                end
                S_SHIFT: begin
                    if (i_sts.idx_zero) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_TRD;
                end
                S_TRD: begin
                    r_state <= S_TWR;
                end
                S_TWR: begin
                    r_res   <= !i_sts.hit;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_acc <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ARWC_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid))
    `ARWC_ASSERT(a_accept_to_cmp, (i_s_tvalid && o_s_tready) |=> (r_state == S_CMP))
    `ARWC_ASSERT(a_drain_after_shift, (r_state == S_DRAIN) |-> ($past(r_state) == S_SHIFT))
    `ARWC_ASSERT(a_old_rejects, (r_state == S_CMP && i_sts.old) |=> (r_state == S_DONE && !r_res))

endmodule

// File: tb/anti_replay_window_check_core_test.sv
`timescale 1ns / 100ps

module anti_replay_window_check_core_test;

    localparam int          WINDOW_BITS = 1024;
    localparam logic [63:0] WINDOW_SPAN = 64'(WINDOW_BITS);
    localparam logic [63:0] CEILING     = '1;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [63:0] i_s_axis_tdata  = '0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;

    // predicted window state: bit k marks counter (top_counter - k) as seen
    logic [WINDOW_BITS-1:0] seen_window = '0;
    logic [63:0]            top_counter = '0;

    bit expected_verdicts[$];
    int verdict_mismatches = 0;
    bit idling = 1'b1;

    anti_replay_window_check_core #(
        .WINDOW_BITS(WINDOW_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit predict_accept(input logic [63:0] counter);
        logic [63:0] gap;
        if (counter < top_counter && top_counter - counter >= WINDOW_SPAN)
            return 1'b0;
        if (counter > top_counter) begin
            gap = counter - top_counter;
            if (gap >= WINDOW_SPAN)
                seen_window = '0;
            else
                seen_window = seen_window << gap;
            top_counter = counter;
        end
        gap = top_counter - counter;
        if (seen_window[gap])
            return 1'b0;
        seen_window[gap] = 1'b1;
        return 1'b1;
    endfunction

    // mostly traffic around the window edge, some far-off noise
    function automatic logic [63:0] pick_counter();
        logic [63:0] step;
        int          r;
        r = $urandom_range(99);
        if (r < 45) begin
            if (r < 30)
                step = 64'($urandom_range(1, 70));
            else if (r < 40)
                step = 64'($urandom_range(1, WINDOW_BITS + 100));
            else
                step = 64'($urandom_range(0, 2) + WINDOW_BITS - 1 -
                            (64 * $urandom_range(0, 3)) * $urandom_range(0, 1));
            if (step == 0)
                step = 1;
            if (step <= CEILING - top_counter)
                return top_counter + step;
            return top_counter;
        end
        if (r < 96) begin
            if (r < 75)
                step = 64'($urandom_range(0, 63));
            else if (r < 88)
                step = 64'($urandom_range(0, WINDOW_BITS - 1));
            else
                step = WINDOW_SPAN + 64'($urandom_range(0, 100));
            if (step > top_counter)
                step = top_counter;
            return top_counter - step;
        end
        return {$urandom, $urandom};
    endfunction

    task automatic send_counter(input logic [63:0] counter);
        while (idling && $urandom_range(99) < 32) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= counter;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_verdicts.push_back(predict_accept(counter));
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= !idling || ($urandom_range(99) >= 32);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                if (verdict_mismatches < 10)
                    $display("unexpected word: actual %02h", o_m_axis_tdata);
                verdict_mismatches++;
            end else if (o_m_axis_tdata !== {7'b0, expected_verdicts[0]}) begin
                if (verdict_mismatches < 10)
                    $display("accepted mismatch: expected %02h actual %02h",
                             {7'b0, expected_verdicts[0]}, o_m_axis_tdata);
                verdict_mismatches++;
                void'(expected_verdicts.pop_front());
            end else begin
                void'(expected_verdicts.pop_front());
            end
        end
    end

    // replays, shifts by whole and partial words, window edge, full clear
    task automatic test_window_edges();
        send_counter(64'd0);
        send_counter(64'd0);
        send_counter(64'd1);
        send_counter(64'd0);
        send_counter(64'd64);
        send_counter(64'd128);
        send_counter(64'd0);
        send_counter(64'd2);
        send_counter(64'd128 + WINDOW_SPAN - 1);
        send_counter(64'd127);
        send_counter(64'd128);
        send_counter(64'd128 + WINDOW_SPAN - 1);
        send_counter(64'd128 + 2 * WINDOW_SPAN - 1);
        send_counter(64'd128 + WINDOW_SPAN);
        send_counter(64'd127 + WINDOW_SPAN);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_counter(pick_counter());
    endtask

    task automatic test_back_to_back(input int count);
        idling = 1'b0;
        repeat (count) send_counter(pick_counter());
        idling = 1'b1;
    endtask

    task automatic test_drain_pause(input int rounds, input int count);
        repeat (rounds) begin
            repeat (count) send_counter(pick_counter());
            wait_drained();
        end
    endtask

    // top of the counter range, age test must not wrap
    task automatic test_counter_ceiling();
        send_counter(CEILING);
        send_counter(CEILING);
        send_counter(CEILING - WINDOW_SPAN + 1);
        send_counter(CEILING - WINDOW_SPAN);
        send_counter(64'd0);
        send_counter(CEILING - 1);
        send_counter(64'h5555_5555_5555_5555);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_window_edges();
        test_random_traffic(1200);
        test_back_to_back(300);
        test_drain_pause(3, 40);
        test_counter_ceiling();
        wait_drained();
        repeat (WINDOW_BITS / 64 + 12) @(posedge i_clk);
        if (verdict_mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("[anti_replay_window_check_core] OK");
        end else begin
            $display("[anti_replay_window_check_core] ERROR");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("[anti_replay_window_check_core] ERROR");
        $finish;
    end

endmodule

// File: anti_replay_window_check_core.f
+incdir+rtl
rtl/arwc_pkg.sv
rtl/arwc_datapath.sv
rtl/arwc_ctrl.sv
rtl/anti_replay_window_check_core.sv
tb/anti_replay_window_check_core_test.sv
